FILE: sv/i2cmbs_pkg.sv
package i2cmbs_pkg;

	// command codes, also used for the sub-sequence selector
	localparam logic [2:0] CMD_NONE  = 3'd0;
	localparam logic [2:0] CMD_START = 3'd1;
	localparam logic [2:0] CMD_STOP  = 3'd2;
	localparam logic [2:0] CMD_WRITE = 3'd3;
	localparam logic [2:0] CMD_ACK   = 3'd4;
	localparam logic [2:0] CMD_READ  = 3'd5;
	localparam logic [2:0] CMD_PROBE = 3'd6;

	// probe layout: start, address write, ack sample, stop
	localparam logic [5:0] PROBE_WR_BASE   = 6'd3;
	localparam logic [5:0] PROBE_ACK_BASE  = 6'd27;
	localparam logic [5:0] PROBE_STOP_BASE = 6'd30;

	// read layout: release slot, two slots per bit, answer bit
	localparam logic [5:0] READ_LAST_BIT = 6'd16;
	localparam logic [5:0] READ_ANS_LOW  = 6'd17;
	localparam logic [5:0] READ_ANS_HIGH = 6'd18;

	localparam logic [2:0] LAST_BIT = 3'd7;

endpackage

FILE: sv/i2c_master_bit_sequencer.sv
// I2C master bit engine: one input word is one bus time slot.
// A result word is registered when its input word is taken and shows in the next cycle.
// Throughput: one word per cycle while the result is not stalled; the single result register frees on take.
// arst_n low clears the sequencer to idle with SCL and SDA released,
// last ack 1, error flag and shift registers 0, and no pending result.
module i2c_master_bit_sequencer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] action,
	input  logic [7:0] tx_byte,
	input  logic       send_ack,
	input  logic       sda_in,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       scl_out,
	output logic       sda_out,
	output logic       busy_res,
	output logic       done_res,
	output logic [7:0] rx_byte,
	output logic       ack_bit,
	output logic       bus_error
);

	logic [2:0] cmd_q, cmd_n;
	logic [5:0] phase_q, phase_n;
	logic [2:0] bc_q, bc_n;
	logic [7:0] tx_q, tx_n;
	logic [7:0] rx_q, rx_n;
	logic       ackc_q, ackc_n;
	logic       scl_q, scl_n;
	logic       sda_q, sda_n;
	logic       la_q, la_n;
	logic       err_q, err_n;
	logic       busy_q, busy_n;
	logic       done_q, done_n;
	logic       valid_q;
	logic       take;

	logic [5:0] ph;
	logic [5:0] sph;
	logic [2:0] kind;
	logic [5:0] wbase;
	logic [1:0] part;
	logic [2:0] wbit;
	logic       fin_sub;
	logic       abort;

	assign in_stall = valid_q & out_stall;
	assign take     = in_valid & ~in_stall;

	always_comb begin
		cmd_n   = cmd_q;
		ph      = phase_q;
		bc_n    = bc_q;
		tx_n    = tx_q;
		rx_n    = rx_q;
		ackc_n  = ackc_q;
		scl_n   = scl_q;
		sda_n   = sda_q;
		la_n    = la_q;
		err_n   = err_q;
		busy_n  = 1'b0;
		done_n  = 1'b0;
		fin_sub = 1'b0;
		abort   = 1'b0;
		phase_n = phase_q;

		// latch a new command only when idle
		if (cmd_q == i2cmbs_pkg::CMD_NONE && action >= i2cmbs_pkg::CMD_START &&
				action <= i2cmbs_pkg::CMD_PROBE) begin
			cmd_n  = action;
			ph     = '0;
			bc_n   = '0;
			tx_n   = tx_byte;
			ackc_n = send_ack;
			if (action == i2cmbs_pkg::CMD_START || action == i2cmbs_pkg::CMD_PROBE)
				err_n = 1'b0;
		end

		// map probe phases onto the basic sequences
		kind = cmd_n;
		sph  = ph;
		if (cmd_n == i2cmbs_pkg::CMD_PROBE) begin
			if (ph < i2cmbs_pkg::PROBE_WR_BASE) begin
				kind = i2cmbs_pkg::CMD_START;
			end else if (ph < i2cmbs_pkg::PROBE_ACK_BASE) begin
				kind = i2cmbs_pkg::CMD_WRITE;
				sph  = ph - i2cmbs_pkg::PROBE_WR_BASE;
			end else if (ph < i2cmbs_pkg::PROBE_STOP_BASE) begin
				kind = i2cmbs_pkg::CMD_ACK;
				sph  = ph - i2cmbs_pkg::PROBE_ACK_BASE;
			end else begin
				kind = i2cmbs_pkg::CMD_STOP;
				sph  = ph - i2cmbs_pkg::PROBE_STOP_BASE;
			end
		end

		// bit counter tracks the write bit, so the slot within a bit is phase - 3*bit
		wbit  = bc_n;
		wbase = {2'b00, wbit, 1'b0} + {3'b000, wbit};
		part  = 2'(sph - wbase);

		case (kind)
			i2cmbs_pkg::CMD_START: begin
				if (sph == 6'd0) begin
					scl_n = 1'b1;
					sda_n = 1'b1;
					if (!sda_in) begin
						err_n = 1'b1;
						abort = 1'b1;
					end
				end else if (sph == 6'd1) begin
					sda_n = 1'b0;
				end else begin
					scl_n   = 1'b0;
					fin_sub = 1'b1;
				end
			end
			i2cmbs_pkg::CMD_STOP: begin
				if (sph == 6'd0) begin
					scl_n = 1'b0;
					sda_n = 1'b0;
				end else if (sph == 6'd1) begin
					scl_n = 1'b1;
				end else begin
					// release SDA only after SCL is already high
					sda_n   = 1'b1;
					fin_sub = 1'b1;
				end
			end
			i2cmbs_pkg::CMD_WRITE: begin
				if (part == 2'd0) begin
					scl_n = 1'b0;
					sda_n = tx_n[7];
				end else if (part == 2'd1) begin
					scl_n = 1'b1;
				end else begin
					scl_n = 1'b0;
					tx_n  = {tx_n[6:0], 1'b0};
					bc_n  = wbit + 3'd1;
					if (wbit == i2cmbs_pkg::LAST_BIT) begin
						sda_n   = 1'b1;
						fin_sub = 1'b1;
					end
				end
			end
			i2cmbs_pkg::CMD_ACK: begin
				if (sph == 6'd0) begin
					sda_n = 1'b1;
				end else if (sph == 6'd1) begin
					scl_n = 1'b1;
					la_n  = sda_in;
				end else begin
					scl_n   = 1'b0;
					fin_sub = 1'b1;
				end
			end
			i2cmbs_pkg::CMD_READ: begin
				if (sph == 6'd0) begin
					sda_n = 1'b1;
				end else if (sph <= i2cmbs_pkg::READ_LAST_BIT) begin
					if (sph[0]) begin
						scl_n = 1'b1;
						rx_n  = {rx_n[6:0], sda_in};
					end else begin
						scl_n = 1'b0;
						bc_n  = sph[3:1];
					end
				end else if (sph == i2cmbs_pkg::READ_ANS_LOW) begin
					scl_n = 1'b0;
					sda_n = ~ackc_n;
				end else if (sph == i2cmbs_pkg::READ_ANS_HIGH) begin
					scl_n = 1'b1;
				end else begin
					scl_n   = 1'b0;
					sda_n   = 1'b1;
					fin_sub = 1'b1;
				end
			end
			default: begin
			end
		endcase

		if (cmd_n != i2cmbs_pkg::CMD_NONE) begin
			busy_n = 1'b1;
			// a probe aborted at start reports no answer
			if (abort && cmd_n == i2cmbs_pkg::CMD_PROBE)
				la_n = 1'b1;
			// inside a probe only the stop part ends the sequence
			if (abort || (fin_sub && (cmd_n != i2cmbs_pkg::CMD_PROBE ||
					kind == i2cmbs_pkg::CMD_STOP))) begin
				done_n  = 1'b1;
				cmd_n   = i2cmbs_pkg::CMD_NONE;
				phase_n = '0;
			end else begin
				phase_n = ph + 6'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q   <= i2cmbs_pkg::CMD_NONE;
			phase_q <= '0;
			bc_q    <= '0;
			tx_q    <= '0;
			rx_q    <= '0;
			ackc_q  <= 1'b0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			la_q    <= 1'b1;
			err_q   <= 1'b0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (take) begin
				cmd_q   <= cmd_n;
				phase_q <= phase_n;
				bc_q    <= bc_n;
				tx_q    <= tx_n;
				rx_q    <= rx_n;
				ackc_q  <= ackc_n;
				scl_q   <= scl_n;
				sda_q   <= sda_n;
				la_q    <= la_n;
				err_q   <= err_n;
				busy_q  <= busy_n;
				done_q  <= done_n;
				valid_q <= 1'b1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	// state registers double as the result word: they only move on a take
	assign out_valid = valid_q;
	assign scl_out   = scl_q;
	assign sda_out   = sda_q;
	assign busy_res  = busy_q;
	assign done_res  = done_q;
	assign rx_byte   = rx_q;
	assign ack_bit   = la_q;
	assign bus_error = err_q;

endmodule

FILE: sv/i2cmbs_checker.sv
module i2cmbs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       scl_out,
	input logic       sda_out,
	input logic       busy_res,
	input logic       done_res,
	input logic [7:0] rx_byte,
	input logic       bus_error
);

	// a finished sequence is always reported as busy in its last slot
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> busy_res)
		else $error("done without busy");

	// a new bus error comes with an aborted start, lines released
	a_err_abort: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(bus_error) |-> out_valid && done_res && scl_out && sda_out)
		else $error("bus error without abort");

	// input backpressure only comes from a pending result word
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with no pending word");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(rx_byte))
		else $error("stalled word dropped or changed");

endmodule

bind i2c_master_bit_sequencer i2cmbs_checker u_i2cmbs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.scl_out   (scl_out),
	.sda_out   (sda_out),
	.busy_res  (busy_res),
	.done_res  (done_res),
	.rx_byte   (rx_byte),
	.bus_error (bus_error)
);

FILE: tb/sv/i2cmbs_slot_checker.sv
`timescale 1ns / 100ps

module i2cmbs_slot_checker
	import i2cmbs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  action,
	input  logic [7:0]  tx_byte,
	input  logic        send_ack,
	input  logic        sda_in,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        scl_out,
	input  logic        sda_out,
	input  logic        busy_res,
	input  logic        done_res,
	input  logic [7:0]  rx_byte,
	input  logic        ack_bit,
	input  logic        bus_error,
	output int unsigned mismatches,
	output int unsigned outstanding
);

	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       busy;
		logic       done;
		logic [7:0] rx;
		logic       ack;
		logic       err;
	} slot_word_t;

	slot_word_t expected_words[$];
	slot_word_t want;
	int unsigned result_index;

	// shadow of the engine
	logic [2:0] run_cmd;
	logic [5:0] phase;
	logic [7:0] tx_shift;
	logic [7:0] rx_shift;
	logic       ack_sel;
	logic       scl_lvl;
	logic       sda_lvl;
	logic       ack_seen;
	logic       err_seen;

	// each slot function: 0 keep going, 1 finished, -1 aborted
	function automatic int start_slot(input int ph, input logic line);
		if (ph == 0) begin
			scl_lvl = 1'b1;
			sda_lvl = 1'b1;
			if (!line) begin
				err_seen = 1'b1;
				return -1;
			end
			return 0;
		end
		if (ph == 1) begin
			sda_lvl = 1'b0;
			return 0;
		end
		scl_lvl = 1'b0;
		return 1;
	endfunction

	function automatic int stop_slot(input int ph);
		if (ph == 0) begin
			scl_lvl = 1'b0;
			sda_lvl = 1'b0;
			return 0;
		end
		if (ph == 1) begin
			scl_lvl = 1'b1;
			return 0;
		end
		// release SDA only after SCL is up
		sda_lvl = 1'b1;
		return 1;
	endfunction

	function automatic int write_slot(input int ph);
		int part;
		int bit_no;
		part = ph % 3;
		bit_no = ph / 3;
		if (part == 0) begin
			scl_lvl = 1'b0;
			sda_lvl = tx_shift[7];
			return 0;
		end
		if (part == 1) begin
			scl_lvl = 1'b1;
			return 0;
		end
		scl_lvl = 1'b0;
		tx_shift = {tx_shift[6:0], 1'b0};
		if (bit_no >= int'(LAST_BIT)) begin
			sda_lvl = 1'b1;
			return 1;
		end
		return 0;
	endfunction

	function automatic int ack_slot(input int ph, input logic line);
		if (ph == 0) begin
			sda_lvl = 1'b1;
			return 0;
		end
		if (ph == 1) begin
			scl_lvl = 1'b1;
			ack_seen = line;
			return 0;
		end
		scl_lvl = 1'b0;
		return 1;
	endfunction

	function automatic int read_slot(input int ph, input logic line);
		if (ph == 0) begin
			sda_lvl = 1'b1;
			return 0;
		end
		if (ph <= int'(READ_LAST_BIT)) begin
			// odd phases raise SCL and sample, even phases drop it
			if (ph[0]) begin
				scl_lvl = 1'b1;
				rx_shift = {rx_shift[6:0], line};
			end else begin
				scl_lvl = 1'b0;
			end
			return 0;
		end
		if (ph == int'(READ_ANS_LOW)) begin
			scl_lvl = 1'b0;
			sda_lvl = !ack_sel;
			return 0;
		end
		if (ph == int'(READ_ANS_HIGH)) begin
			scl_lvl = 1'b1;
			return 0;
		end
		scl_lvl = 1'b0;
		sda_lvl = 1'b1;
		return 1;
	endfunction

	function automatic int probe_slot(input int ph, input logic line);
		int step;
		if (ph < int'(PROBE_WR_BASE)) begin
			step = start_slot(ph, line);
			if (step < 0) begin
				// nobody can answer on a stuck bus
				ack_seen = 1'b1;
				return -1;
			end
			return 0;
		end
		if (ph < int'(PROBE_ACK_BASE)) begin
			step = write_slot(ph - int'(PROBE_WR_BASE));
			return 0;
		end
		if (ph < int'(PROBE_STOP_BASE)) begin
			step = ack_slot(ph - int'(PROBE_ACK_BASE), line);
			return 0;
		end
		return stop_slot(ph - int'(PROBE_STOP_BASE));
	endfunction

	function automatic slot_word_t predict_slot(input logic [2:0] act, input logic [7:0] tx,
			input logic ack_req, input logic line);
		slot_word_t w;
		int step;
		w = '0;
		step = 0;
		if (run_cmd == CMD_NONE && act >= CMD_START && act <= CMD_PROBE) begin
			run_cmd = act;
			phase = '0;
			tx_shift = tx;
			ack_sel = ack_req;
			if (act == CMD_START || act == CMD_PROBE)
				err_seen = 1'b0;
		end
		if (run_cmd != CMD_NONE) begin
			w.busy = 1'b1;
			case (run_cmd)
				CMD_START: step = start_slot(int'(phase), line);
				CMD_STOP:  step = stop_slot(int'(phase));
				CMD_WRITE: step = write_slot(int'(phase));
				CMD_ACK:   step = ack_slot(int'(phase), line);
				CMD_READ:  step = read_slot(int'(phase), line);
				default:   step = probe_slot(int'(phase), line);
			endcase
			if (step != 0) begin
				w.done = 1'b1;
				run_cmd = CMD_NONE;
				phase = '0;
			end else begin
				phase = phase + 6'd1;
			end
		end
		w.scl = scl_lvl;
		w.sda = sda_lvl;
		w.rx = rx_shift;
		w.ack = ack_seen;
		w.err = err_seen;
		return w;
	endfunction

	task automatic check_field(input string field, input logic [7:0] exp_val,
			input logic [7:0] got_val);
		if (got_val !== exp_val) begin
			mismatches++;
			if (mismatches <= 10)
				$display("word %0d: %s expected %0h, got %0h", result_index, field,
					exp_val, got_val);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_cmd = CMD_NONE;
			phase = '0;
			tx_shift = '0;
			rx_shift = '0;
			ack_sel = 1'b0;
			scl_lvl = 1'b1;
			sda_lvl = 1'b1;
			ack_seen = 1'b1;
			err_seen = 1'b0;
			expected_words.delete();
			result_index = 0;
			mismatches = 0;
			outstanding = 0;
		end else begin
			// compare first: a word taken at this edge cannot be answered at it
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("word %0d: result with nothing pending", result_index);
				end else begin
					want = expected_words.pop_front();
					check_field("scl_out", 8'(want.scl), 8'(scl_out));
					check_field("sda_out", 8'(want.sda), 8'(sda_out));
					check_field("busy_res", 8'(want.busy), 8'(busy_res));
					check_field("done_res", 8'(want.done), 8'(done_res));
					check_field("rx_byte", want.rx, rx_byte);
					check_field("ack_bit", 8'(want.ack), 8'(ack_bit));
					check_field("bus_error", 8'(want.err), 8'(bus_error));
				end
				result_index++;
			end
			if (in_valid && !in_stall)
				expected_words.push_back(predict_slot(action, tx_byte, send_ack, sda_in));
			outstanding = expected_words.size();
		end
	end

endmodule

FILE: tb/sv/i2c_master_bit_sequencer_tb.sv
`timescale 1ns / 100ps

module i2c_master_bit_sequencer_tb;
	import i2cmbs_pkg::*;

	localparam logic [2:0] ACT_UNUSED = 3'd7;
	localparam int unsigned RANDOM_SLOTS = 650;
	localparam int unsigned HOLDOFF_CYCLES = 80;
	localparam int unsigned CYCLE_LIMIT = 200000;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [2:0] action;
	logic [7:0] tx_byte;
	logic       send_ack;
	logic       sda_in;
	logic       out_valid;
	logic       out_stall;
	logic       scl_out;
	logic       sda_out;
	logic       busy_res;
	logic       done_res;
	logic [7:0] rx_byte;
	logic       ack_bit;
	logic       bus_error;

	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned cycle_count = 0;
	int unsigned counted_slots = 0;
	int unsigned send_idle_pct = 21;
	int unsigned recv_idle_pct = 58;
	logic        holdoff_go = 1'b0;
	logic        holdoff_done = 1'b0;

	i2c_master_bit_sequencer dut (.*);

	i2cmbs_slot_checker checker_i (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (holdoff_go && !holdoff_done) begin
				out_stall <= 1'b1;
				repeat (HOLDOFF_CYCLES) @(negedge clk);
				holdoff_done = 1'b1;
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// enter and leave at a falling edge
	task automatic send_slot(input logic [2:0] act, input logic [7:0] tx, input logic ack_req,
			input logic line);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		tx_byte <= tx;
		send_ack <= ack_req;
		sda_in <= line;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// issue a command on an idle engine and feed the slots it needs
	task automatic run_command(input logic [2:0] cmd, input logic [7:0] tx,
			input logic ack_req, input logic abort);
		int unsigned len;
		int unsigned i;
		logic first_line;
		logic [2:0] noise;
		case (cmd)
			CMD_WRITE: len = 24;
			CMD_READ:  len = 20;
			CMD_PROBE: len = 33;
			default:   len = 3;
		endcase
		first_line = 1'($urandom_range(1));
		if (cmd == CMD_START || cmd == CMD_PROBE) begin
			// SDA low in the first slot aborts the sequence
			first_line = !abort;
			if (abort)
				len = 1;
		end
		send_slot(cmd, tx, ack_req, first_line);
		for (i = 1; i < len; i++) begin
			// commands offered while busy must be dropped
			noise = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : CMD_NONE;
			send_slot(noise, 8'($urandom_range(255)), 1'($urandom_range(1)),
				1'($urandom_range(1)));
		end
		counted_slots += len;
	endtask

	task automatic run_transfer();
		logic [7:0] addr;
		int unsigned n_bytes;
		int unsigned i;
		addr = 8'($urandom_range(255));
		n_bytes = $urandom_range(3);
		run_command(CMD_START, 8'($urandom_range(255)), 1'($urandom_range(1)),
			$urandom_range(9) == 0);
		run_command(CMD_WRITE, addr, 1'($urandom_range(1)), 1'b0);
		run_command(CMD_ACK, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0);
		for (i = 0; i < n_bytes; i++) begin
			if (addr[0]) begin
				// ACK every byte but the last
				run_command(CMD_READ, 8'($urandom_range(255)), i != n_bytes - 1, 1'b0);
			end else begin
				run_command(CMD_WRITE, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0);
				run_command(CMD_ACK, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0);
			end
		end
		run_command(CMD_STOP, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
	endtask

	initial begin : stimulus
		int unsigned directed_slots;
		int unsigned progress;
		int unsigned stage;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = CMD_NONE;
		tx_byte = '0;
		send_ack = 1'b0;
		sda_in = 1'b1;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_slot(CMD_NONE, 8'h00, 1'b0, 1'b0);
		send_slot(ACT_UNUSED, 8'hFF, 1'b1, 1'b1);
		run_command(CMD_START, 8'h00, 1'b0, 1'b1);
		run_command(CMD_START, 8'hFF, 1'b1, 1'b0);
		run_command(CMD_WRITE, 8'h00, 1'b0, 1'b0);
		run_command(CMD_WRITE, 8'hFF, 1'b1, 1'b0);
		run_command(CMD_WRITE, 8'hA5, 1'b0, 1'b0);
		run_command(CMD_ACK, 8'h00, 1'b0, 1'b0);
		run_command(CMD_READ, 8'h00, 1'b1, 1'b0);
		run_command(CMD_READ, 8'hFF, 1'b0, 1'b0);
		run_command(CMD_STOP, 8'h00, 1'b0, 1'b0);
		// stop on a bus that is already free
		run_command(CMD_STOP, 8'hFF, 1'b1, 1'b0);
		run_command(CMD_PROBE, 8'h00, 1'b0, 1'b0);
		run_command(CMD_PROBE, 8'hFF, 1'b1, 1'b0);
		run_command(CMD_PROBE, 8'h5A, 1'b0, 1'b1);
		run_command(CMD_ACK, 8'hFF, 1'b1, 1'b0);
		wait_drained();

		directed_slots = counted_slots;
		stage = 0;
		while (counted_slots - directed_slots < RANDOM_SLOTS) begin
			progress = counted_slots - directed_slots;
			if (stage == 0 && progress >= RANDOM_SLOTS / 3) begin
				stage = 1;
				wait_drained();
				send_idle_pct = 58;
				recv_idle_pct = 21;
			end else if (stage == 1 && progress >= 2 * RANDOM_SLOTS / 3) begin
				stage = 2;
				wait_drained();
				send_idle_pct = 0;
				recv_idle_pct = 0;
				// keep offering words while the receiver holds off
				holdoff_go = 1'b1;
			end
			case ($urandom_range(9))
				6, 7: run_command(CMD_PROBE, 8'($urandom_range(255)), 1'($urandom_range(1)),
					$urandom_range(9) == 0);
				8: run_command(3'($urandom_range(6, 1)), 8'($urandom_range(255)),
					1'($urandom_range(1)), $urandom_range(7) == 0);
				9: begin
					repeat ($urandom_range(3, 1))
						send_slot($urandom_range(1) ? ACT_UNUSED : CMD_NONE,
							8'($urandom_range(255)), 1'($urandom_range(1)),
							1'($urandom_range(1)));
				end
				default: run_transfer();
			endcase
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
